>>> design/bpa_pkg.sv
// shared constants and codes for the block pool allocator
package bpa_pkg;
   localparam int NUM_BLOCKS  = 1024;
   localparam int BLK_W       = $clog2(NUM_BLOCKS);
   localparam int CNT_W       = BLK_W + 1;
   localparam int MAX_ALLOCS  = 128;
   localparam int LIVE_W      = $clog2(MAX_ALLOCS + 1);
   localparam int BLOCK_SHIFT = 5;
   localparam int SIZE_W      = 16;
   localparam int NREQ_W      = SIZE_W + 1 - BLOCK_SHIFT;
   localparam int ADDR_W      = 32;
   localparam int POOL_W      = 11;

   localparam logic       OP_RESERVE = 1'b0;
   localparam logic       OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic       CSR_POOL_BASE   = 1'b0;
   localparam logic       CSR_POOL_BLOCKS = 1'b1;

   typedef logic [BLK_W-1:0] blk_type;
   typedef logic [CNT_W-1:0] cnt_type;
endpackage

>>> design/bpa_ifs.sv
// request, response and register write channels
interface bpa_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] size_bytes;
   logic        want_place;
   logic [31:0] address;
   modport source (output valid, operation, size_bytes, want_place, address, input ready);
   modport sink   (input valid, operation, size_bytes, want_place, address, output ready);
endinterface

interface bpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] granted_address;
   logic [31:0] stamp;
   logic [15:0] freed_bytes;
   modport source (output valid, status, granted_address, stamp, freed_bytes, input ready);
   modport sink   (input valid, status, granted_address, stamp, freed_bytes, output ready);
endinterface

interface bpa_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/bpa_ram.sv
// generic ram, one write port and one registered read port
module bpa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/block_pool_allocator.sv
// block pool allocator: first-fit or placed reserve and release over a block map
// after reset a clearing pass sets every block free and every stored length to zero; no request taken meanwhile
// first fit scans the map for a free run, then writes it; placed reserve runs a check pass then a write pass
// release reads the stored length, then runs a write pass; a rejected request goes straight to the response
// one transaction in flight, next one accepted the cycle after the response transaction
// reset is synchronous, active high; registers come back to pool_base 0, pool_blocks 1024
module block_pool_allocator (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_port,
   bpa_rsp_if.source rsp_port,
   bpa_csr_if.sink   csr_port
);
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FIT   = 3'd3;
   localparam logic [2:0] S_LREQ  = 3'd4;
   localparam logic [2:0] S_LCHK  = 3'd5;
   localparam logic [2:0] S_WRITE = 3'd6;
   localparam logic [2:0] S_RESP  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [31:0] base_ff, base_in;
   logic [bpa_pkg::POOL_W-1:0] blocks_ff, blocks_in;
   logic [bpa_pkg::LIVE_W-1:0] live_ff, live_in;
   bpa_pkg::blk_type clr_ff, clr_in;
   logic place_ff, place_in;
   logic [bpa_pkg::NREQ_W-1:0] n_ff, n_in;
   bpa_pkg::blk_type start_ff, start_in;
   bpa_pkg::cnt_type iss_ff, iss_in, end_ff, end_in, run_ff, run_in;
   bpa_pkg::blk_type chk_ff, chk_in, wa_ff, wa_in;
   bpa_pkg::cnt_type cnt_ff, cnt_in;
   logic vld_ff, vld_in, wval_ff, wval_in;
   logic [1:0] status_ff, status_in;
   logic [31:0] granted_ff, granted_in, stamp_ff, stamp_in;
   logic [15:0] freed_ff, freed_in;

   logic free_we, free_wd, free_rd;
   bpa_pkg::blk_type free_wa;
   logic len_we;
   bpa_pkg::blk_type len_wa;
   bpa_pkg::cnt_type len_wd, len_rd;

   logic [31:0] rel;
   logic [26:0] blk;
   bpa_pkg::cnt_type eff, run_nx;
   logic [bpa_pkg::SIZE_W:0] size_up;
   logic [bpa_pkg::NREQ_W-1:0] n_req;

   bpa_ram #(.WIDTH(1), .DEPTH(bpa_pkg::NUM_BLOCKS)) u_free_ram (
      .clock(clock), .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(iss_ff[bpa_pkg::BLK_W-1:0]), .rd_data(free_rd)
   );

   bpa_ram #(.WIDTH(bpa_pkg::CNT_W), .DEPTH(bpa_pkg::NUM_BLOCKS)) u_len_ram (
      .clock(clock), .wr_en(len_we), .wr_addr(len_wa), .wr_data(len_wd),
      .rd_addr(start_ff), .rd_data(len_rd)
   );

   assign req_port.ready           = (state_ff == S_IDLE);
   assign rsp_port.valid           = (state_ff == S_RESP);
   assign rsp_port.status          = status_ff;
   assign rsp_port.granted_address = granted_ff;
   assign rsp_port.stamp           = stamp_ff;
   assign rsp_port.freed_bytes     = freed_ff;
   assign csr_port.ready           = 1'b1;

   assign eff = (blocks_ff > bpa_pkg::CNT_W'(bpa_pkg::NUM_BLOCKS))
      ? bpa_pkg::CNT_W'(bpa_pkg::NUM_BLOCKS) : bpa_pkg::CNT_W'(blocks_ff);
   assign rel     = req_port.address - base_ff;
   assign blk     = rel[31:bpa_pkg::BLOCK_SHIFT];
   assign size_up = {1'b0, req_port.size_bytes} + (bpa_pkg::SIZE_W+1)'(31);
   assign n_req   = size_up[bpa_pkg::SIZE_W:bpa_pkg::BLOCK_SHIFT];
   assign run_nx  = free_rd ? run_ff + 1'b1 : '0;

   always_comb begin
      state_in   = state_ff;
      base_in    = base_ff;
      blocks_in  = blocks_ff;
      live_in    = live_ff;
      clr_in     = clr_ff;
      place_in   = place_ff;
      n_in       = n_ff;
      start_in   = start_ff;
      iss_in     = iss_ff;
      end_in     = end_ff;
      run_in     = run_ff;
      chk_in     = chk_ff;
      vld_in     = 1'b0;
      wa_in      = wa_ff;
      cnt_in     = cnt_ff;
      wval_in    = wval_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      stamp_in   = stamp_ff;
      freed_in   = freed_ff;
      free_we    = 1'b0;
      free_wa    = wa_ff;
      free_wd    = wval_ff;
      len_we     = 1'b0;
      len_wa     = start_ff;
      len_wd     = '0;

      if (csr_port.valid) begin
         unique case (csr_port.index)
            bpa_pkg::CSR_POOL_BASE:   base_in   = csr_port.data;
            bpa_pkg::CSR_POOL_BLOCKS: blocks_in = csr_port.data[bpa_pkg::POOL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            free_we = 1'b1;
            free_wa = clr_ff;
            free_wd = 1'b1;
            len_we  = 1'b1;
            len_wa  = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_port.valid) begin
               status_in  = bpa_pkg::ST_IGNORED;
               granted_in = '0;
               stamp_in   = '0;
               freed_in   = '0;
               place_in   = req_port.want_place;
               n_in       = n_req;
               run_in     = '0;
               state_in   = S_RESP;
               if (req_port.operation == bpa_pkg::OP_RESERVE) begin
                  if (req_port.size_bytes != '0) begin
                     if (req_port.want_place) begin
                        if (rel[bpa_pkg::BLOCK_SHIFT-1:0] == '0 && blk < 27'(eff)
                            && n_req <= bpa_pkg::NREQ_W'(eff - blk[bpa_pkg::CNT_W-1:0])) begin
                           start_in = blk[bpa_pkg::BLK_W-1:0];
                           iss_in   = blk[bpa_pkg::CNT_W-1:0];
                           end_in   = blk[bpa_pkg::CNT_W-1:0] + n_req[bpa_pkg::CNT_W-1:0];
                           state_in = S_SCAN;
                        end else begin
                           status_in = bpa_pkg::ST_NOFIT;
                        end
                     end else begin
                        iss_in   = '0;
                        end_in   = eff;
                        state_in = S_SCAN;
                     end
                  end
               end else if (rel[bpa_pkg::BLOCK_SHIFT-1:0] == '0 && blk < 27'(eff)) begin
                  start_in = blk[bpa_pkg::BLK_W-1:0];
                  state_in = S_LREQ;
               end
            end
         end
         S_SCAN: begin
            // reads are issued ahead of the check of the returned bit, which the ram registers
            if (iss_ff < end_ff) begin
               iss_in = iss_ff + 1'b1;
               vld_in = 1'b1;
               chk_in = iss_ff[bpa_pkg::BLK_W-1:0];
            end
            if (vld_ff) begin
               if (!place_ff) begin
                  run_in = run_nx;
                  if ({1'b0, run_nx} >= n_ff) begin
                     start_in = chk_ff + 1'b1 - n_ff[bpa_pkg::BLK_W-1:0];
                     state_in = S_FIT;
                  end
               end else if (!free_rd) begin
                  status_in = bpa_pkg::ST_NOFIT;
                  state_in  = S_RESP;
               end
            end else if (iss_ff >= end_ff) begin
               if (place_ff) begin
                  state_in = S_FIT;
               end else begin
                  status_in = bpa_pkg::ST_NOFIT;
                  state_in  = S_RESP;
               end
            end
         end
         S_FIT: begin
            if (live_ff >= bpa_pkg::LIVE_W'(bpa_pkg::MAX_ALLOCS)) begin
               status_in = bpa_pkg::ST_FULL;
               state_in  = S_RESP;
            end else begin
               len_we     = 1'b1;
               len_wd     = n_ff[bpa_pkg::CNT_W-1:0];
               live_in    = live_ff + 1'b1;
               wa_in      = start_ff;
               cnt_in     = n_ff[bpa_pkg::CNT_W-1:0];
               wval_in    = 1'b0;
               status_in  = bpa_pkg::ST_OK;
               granted_in = base_ff + {(32-bpa_pkg::BLK_W-bpa_pkg::BLOCK_SHIFT)'(0), start_ff,
                                       bpa_pkg::BLOCK_SHIFT'(0)};
               stamp_in   = {16'(start_ff), 16'(n_ff)};
               state_in   = S_WRITE;
            end
         end
         S_LREQ: begin
            state_in = S_LCHK;
         end
         S_LCHK: begin
            if (len_rd == '0) begin
               state_in = S_RESP;
            end else begin
               len_we    = 1'b1;
               if (live_ff != '0) begin
                  live_in = live_ff - 1'b1;
               end
               wa_in     = start_ff;
               cnt_in    = len_rd;
               wval_in   = 1'b1;
               status_in = bpa_pkg::ST_OK;
               freed_in  = 16'({len_rd, bpa_pkg::BLOCK_SHIFT'(0)});
               state_in  = S_WRITE;
            end
         end
         S_WRITE: begin
            free_we = 1'b1;
            wa_in   = wa_ff + 1'b1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == bpa_pkg::CNT_W'(1)) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_port.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         base_ff   <= '0;
         blocks_ff <= bpa_pkg::POOL_W'(1024);
         live_ff   <= '0;
         clr_ff    <= '0;
         vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         base_ff   <= base_in;
         blocks_ff <= blocks_in;
         live_ff   <= live_in;
         clr_ff    <= clr_in;
         vld_ff    <= vld_in;
      end
      place_ff   <= place_in;
      n_ff       <= n_in;
      start_ff   <= start_in;
      iss_ff     <= iss_in;
      end_ff     <= end_in;
      run_ff     <= run_in;
      chk_ff     <= chk_in;
      wa_ff      <= wa_in;
      cnt_ff     <= cnt_in;
      wval_ff    <= wval_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      stamp_ff   <= stamp_in;
      freed_ff   <= freed_in;
   end
endmodule

>>> sim/bpa_alloc_checker.sv
// checker for the block pool allocator: tracks pool state, predicts and compares responses
module bpa_alloc_checker (
   input  logic clock,
   input  logic reset,
   bpa_req_if   req_port,
   bpa_rsp_if   rsp_port,
   bpa_csr_if   csr_port,
   output int   mismatch_count,
   output int   pending_count
);
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted_address;
      logic [31:0] stamp;
      logic [15:0] freed_bytes;
   } alloc_result_type;

   logic [31:0]      base_addr;
   logic [bpa_pkg::POOL_W-1:0] block_limit;
   bit               blk_is_free [bpa_pkg::NUM_BLOCKS];
   int unsigned      run_length [bpa_pkg::NUM_BLOCKS];
   int unsigned      live_count;
   alloc_result_type expected_q [$];

   function automatic alloc_result_type predict_alloc(input logic op, input logic [15:0] size,
                                                      input logic place,
                                                      input logic [31:0] addr);
      alloc_result_type res;
      int unsigned   eff;
      logic [31:0]   rel;
      int unsigned   n;
      int unsigned   start;
      int unsigned   run;
      bit            fit;
      res = '{bpa_pkg::ST_IGNORED, 32'd0, 32'd0, 16'd0};
      eff = (block_limit < bpa_pkg::NUM_BLOCKS) ? 32'(block_limit) : bpa_pkg::NUM_BLOCKS;
      rel = addr - base_addr;
      fit = 0;
      start = 0;
      if (op == bpa_pkg::OP_RESERVE) begin
         if (size != 0) begin
            n = (int'(size) + 31) / 32;
            if (place) begin
               start = rel >> bpa_pkg::BLOCK_SHIFT;
               if (rel[4:0] == 0 && (rel >> bpa_pkg::BLOCK_SHIFT) < eff && n <= eff - start) begin
                  fit = 1;
                  for (int i = start; i < start + n; i++)
                     if (!blk_is_free[i]) fit = 0;
               end
            end else begin
               run = 0;
               for (int i = 0; i < eff && !fit; i++) begin
                  run = blk_is_free[i] ? run + 1 : 0;
                  if (run >= n) begin
                     fit = 1;
                     start = i + 1 - n;
                  end
               end
            end
            if (!fit) begin
               res.status = bpa_pkg::ST_NOFIT;
            end else if (live_count >= bpa_pkg::MAX_ALLOCS) begin
               res.status = bpa_pkg::ST_FULL;
            end else begin
               for (int i = start; i < start + n; i++) blk_is_free[i] = 0;
               run_length[start] = n;
               live_count++;
               res.status = bpa_pkg::ST_OK;
               res.granted_address = base_addr + 32'(start * 32);
               res.stamp = (32'(start) << 16) | 32'(n);
            end
         end
      end else if (rel[4:0] == 0 && (rel >> bpa_pkg::BLOCK_SHIFT) < eff) begin
         start = rel >> bpa_pkg::BLOCK_SHIFT;
         n = run_length[start];
         if (n != 0) begin
            for (int i = start; i < start + n && i < bpa_pkg::NUM_BLOCKS; i++)
               blk_is_free[i] = 1;
            run_length[start] = 0;
            if (live_count > 0) live_count--;
            res.status = bpa_pkg::ST_OK;
            res.freed_bytes = 16'(n * 32);
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         base_addr <= 32'd0;
         block_limit <= 11'd1024;
         for (int i = 0; i < bpa_pkg::NUM_BLOCKS; i++) begin
            blk_is_free[i] = 1;
            run_length[i] = 0;
         end
         live_count = 0;
         expected_q.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp_port.valid && rsp_port.ready) begin
            if (expected_q.size() == 0) begin
               $error("response transaction with nothing expected");
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_port.status !== want.status ||
                   rsp_port.granted_address !== want.granted_address ||
                   rsp_port.stamp !== want.stamp ||
                   rsp_port.freed_bytes !== want.freed_bytes)
                  mismatch_count <= mismatch_count + 1;
               if (rsp_port.status !== want.status)
                  $error("status: expected %0d, got %0d", want.status, rsp_port.status);
               if (rsp_port.granted_address !== want.granted_address)
                  $error("granted_address: expected %h, got %h",
                         want.granted_address, rsp_port.granted_address);
               if (rsp_port.stamp !== want.stamp)
                  $error("stamp: expected %h, got %h", want.stamp, rsp_port.stamp);
               if (rsp_port.freed_bytes !== want.freed_bytes)
                  $error("freed_bytes: expected %0d, got %0d",
                         want.freed_bytes, rsp_port.freed_bytes);
            end
         end
         if (req_port.valid && req_port.ready)
            expected_q.push_back(predict_alloc(req_port.operation, req_port.size_bytes,
                                               req_port.want_place, req_port.address));
         if (csr_port.valid && csr_port.ready) begin
            if (csr_port.index == bpa_pkg::CSR_POOL_BASE) base_addr <= csr_port.data;
            else block_limit <= csr_port.data[bpa_pkg::POOL_W-1:0];
         end
      end
      pending_count <= expected_q.size();
   end
endmodule

>>> sim/tb_block_pool_allocator.sv
// testbench top for the block pool allocator: stimulus, flow control and verdict
module tb_block_pool_allocator;
   logic clock = 0;
   logic reset = 1;
   int   mismatches;
   int   pending;
   bit   quiet = 0;
   bit   long_stall_req = 0;
   bit   long_stall_done = 0;
   logic [31:0]  cur_base;
   int unsigned  cur_blocks;
   logic [31:0]  granted_q [$];

   bpa_req_if req_bus ();
   bpa_rsp_if rsp_bus ();
   bpa_csr_if csr_bus ();

   block_pool_allocator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   bpa_alloc_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_port       (req_bus),
      .rsp_port       (rsp_bus),
      .csr_port       (csr_bus),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   always #4 clock = ~clock;

   initial begin
      #60000000;
      $display("block_pool_allocator: mismatch");
      $finish;
   end

   // remember granted regions so releases can hit recorded allocations
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready && rsp_bus.status == bpa_pkg::ST_OK &&
          rsp_bus.stamp != 0)
         granted_q.push_back(rsp_bus.granted_address);
   end

   // response side flow control
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(posedge clock);
         if (long_stall_req && !long_stall_done) begin
            rsp_bus.ready <= 0;
            long_stall_done = 1;
            repeat (400) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(1, 18) - 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1;
         end
      end
   end

   task automatic send_item(input logic op, input logic [15:0] size, input logic place,
                            input logic [31:0] addr);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid      <= 1;
      req_bus.operation  <= op;
      req_bus.size_bytes <= size;
      req_bus.want_place <= place;
      req_bus.address    <= addr;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain;
      req_bus.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 0;
      if (idx == bpa_pkg::CSR_POOL_BASE) cur_base = value;
      else cur_blocks = 32'(value[bpa_pkg::POOL_W-1:0]);
      @(posedge clock);
   endtask

   task automatic random_item(input int reserve_pct);
      int unsigned eff;
      int unsigned pick;
      logic [15:0] size;
      logic [31:0] addr;
      eff = (cur_blocks < bpa_pkg::NUM_BLOCKS) ? cur_blocks : bpa_pkg::NUM_BLOCKS;
      case ($urandom_range(0, 9))
         0:       size = 16'($urandom);
         1, 2:    size = 16'($urandom_range(1, 32 * (eff + 1)));
         default: size = 16'($urandom_range(1, 256));
      endcase
      if ($urandom_range(0, 99) < reserve_pct) begin
         if ($urandom_range(0, 4) == 0) begin
            addr = cur_base + 32 * $urandom_range(0, eff);
            if ($urandom_range(0, 9) == 0) addr = $urandom;
            else if ($urandom_range(0, 9) == 0) addr = addr + $urandom_range(1, 31);
            send_item(bpa_pkg::OP_RESERVE, size, 1'b1, addr);
         end else begin
            send_item(bpa_pkg::OP_RESERVE, ($urandom_range(0, 30) == 0) ? 16'd0 : size, 1'b0,
                      $urandom);
         end
      end else begin
         if (granted_q.size() != 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, granted_q.size() - 1);
            addr = granted_q[pick];
            granted_q.delete(pick);
         end else if ($urandom_range(0, 1) == 0) begin
            addr = cur_base + 32 * $urandom_range(0, eff + 2) +
                   (($urandom_range(0, 4) == 0) ? $urandom_range(1, 31) : 0);
         end else begin
            addr = $urandom;
         end
         send_item(bpa_pkg::OP_RELEASE, 16'($urandom), 1'($urandom_range(0, 1)), addr);
      end
   endtask

   initial begin
      logic [31:0] b;
      req_bus.valid = 0;
      req_bus.operation = bpa_pkg::OP_RESERVE;
      req_bus.size_bytes = 0;
      req_bus.want_place = 0;
      req_bus.address = 0;
      csr_bus.valid = 0;
      csr_bus.index = bpa_pkg::CSR_POOL_BASE;
      csr_bus.data = 0;
      cur_base = 0;
      cur_blocks = 1024;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      csr_write(bpa_pkg::CSR_POOL_BASE, 32'h0000_1000);
      csr_write(bpa_pkg::CSR_POOL_BLOCKS, 32'd1024);
      b = cur_base;
      send_item(bpa_pkg::OP_RESERVE, 16'd0, 1'b0, 32'd0);
      send_item(bpa_pkg::OP_RESERVE, 16'd1, 1'b0, 32'd0);
      send_item(bpa_pkg::OP_RESERVE, 16'd32768, 1'b0, 32'd0);
      send_item(bpa_pkg::OP_RELEASE, 16'd0, 1'b0, b);
      send_item(bpa_pkg::OP_RESERVE, 16'd32768, 1'b0, 32'd0);
      send_item(bpa_pkg::OP_RELEASE, 16'hFFFF, 1'b1, b);
      send_item(bpa_pkg::OP_RESERVE, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
      send_item(bpa_pkg::OP_RESERVE, 16'd64, 1'b1, b + 32 * 10);
      send_item(bpa_pkg::OP_RESERVE, 16'd64, 1'b1, b + 32 * 10);
      send_item(bpa_pkg::OP_RESERVE, 16'd32, 1'b1, b + 32 * 20 + 4);
      send_item(bpa_pkg::OP_RESERVE, 16'd32, 1'b1, b - 32);
      send_item(bpa_pkg::OP_RESERVE, 16'd64, 1'b1, b + 32 * 1023);
      send_item(bpa_pkg::OP_RESERVE, 16'd32, 1'b1, b + 32 * 1023);
      send_item(bpa_pkg::OP_RELEASE, 16'd0, 1'b0, b + 32 * 10 + 1);
      send_item(bpa_pkg::OP_RELEASE, 16'd0, 1'b0, b + 32 * 11);
      send_item(bpa_pkg::OP_RELEASE, 16'd0, 1'b0, 32'hFFFF_FFFF);
      send_item(bpa_pkg::OP_RELEASE, 16'd0, 1'b0, b + 32 * 5000);
      send_item(bpa_pkg::OP_RESERVE, 16'd96, 1'b0, 32'd0);
      send_item(bpa_pkg::OP_RELEASE, 16'd0, 1'b0, b + 32 * 10);
      send_item(bpa_pkg::OP_RESERVE, 16'd40, 1'b0, 32'd0);
      send_item(bpa_pkg::OP_RELEASE, 16'd0, 1'b0, b + 32 * 1023);
      send_item(bpa_pkg::OP_RESERVE, 16'hFFFF, 1'b1, 32'hFFFF_FFE0);
      drain();

      // reserve heavy so the allocation table runs full; long receiver hold-off midway
      for (int k = 0; k < 160; k++) begin
         if (k == 60) long_stall_req <= 1;
         random_item(k < 140 ? 85 : 30);
      end
      drain();

      // shrunk pool: allocations beyond the end can be neither granted nor released
      csr_write(bpa_pkg::CSR_POOL_BLOCKS, 32'd16);
      for (int k = 0; k < 50; k++) random_item(45);
      drain();

      // base near the top of the address space so granted addresses wrap
      csr_write(bpa_pkg::CSR_POOL_BASE, 32'hFFFF_FF00);
      csr_write(bpa_pkg::CSR_POOL_BLOCKS, 32'h7FF);
      for (int k = 0; k < 70; k++) random_item(55);
      drain();

      csr_write(bpa_pkg::CSR_POOL_BLOCKS, 32'h0);
      csr_write(bpa_pkg::CSR_POOL_BASE, $urandom);
      for (int k = 0; k < 20; k++) random_item(60);
      drain();

      csr_write(bpa_pkg::CSR_POOL_BLOCKS, 32'd1);
      for (int k = 0; k < 25; k++) random_item(50);
      drain();

      csr_write(bpa_pkg::CSR_POOL_BASE, $urandom & 32'hFFFF_FFE0);
      csr_write(bpa_pkg::CSR_POOL_BLOCKS, 32'd1024);
      quiet = 1;
      for (int k = 0; k < 100; k++) random_item(55);
      drain();

      if (mismatches == 0)
         $display("block_pool_allocator: match");
      else
         $display("block_pool_allocator: mismatch");
      $finish;
   end
endmodule
